// File: rtl/core/e2q_pkg.sv
// Shared constants for the Euler-to-quaternion converter: CORDIC arctangent
// table, gain-compensated unit vector and datapath widths.
// No dependencies.
package e2q_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int VEC_W        = 34;   // CORDIC x/y/z, Q2.30 with headroom
  localparam int TRIG_W       = 32;   // sine/cosine out of a lane, Q30
  localparam int MERGE_STAGES = 4;    // pair product, pair round, triple product, finish

  localparam logic signed [VEC_W-1:0] CORDIC_ONE = 34'sd652032874;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [VEC_W-1:0]  vec_t;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458905, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
  };

endpackage

// File: rtl/core/e2q_cordic_lane.sv
// One sine/cosine lane: half-angle phase, quadrant fold and a fully
// pipelined rotation-mode CORDIC. Depends on e2q_pkg.
module e2q_cordic_lane #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [15:0]         angle,
  output e2q_pkg::trig_t      sin_val,
  output e2q_pkg::trig_t      cos_val
);

  localparam int STEPS = e2q_pkg::CORDIC_STEPS;

  logic [23:0] ang_ext;
  logic [23:0] ang_mask;
  logic [30:0] phase;

  e2q_pkg::vec_t x [STEPS+1];
  e2q_pkg::vec_t y [STEPS+1];
  e2q_pkg::vec_t z [STEPS+1];
  logic          upper [STEPS+1];

  // form the half angle as a 2^32-per-turn phase in [0, 2^31)
  assign ang_ext  = {8'd0, angle};
  assign ang_mask = 24'((25'd1 << ANGLE_BITS) - 25'd1);
  assign phase    = 31'(ang_ext & ang_mask) << (31 - ANGLE_BITS);

  // load the vector and fold the upper quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      upper[0] <= phase[30];
      x[0]     <= e2q_pkg::CORDIC_ONE;
      y[0]     <= '0;
      z[0]     <= e2q_pkg::vec_t'({1'b0, phase[29:0]});
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    e2q_pkg::vec_t dx;
    e2q_pkg::vec_t dy;
    e2q_pkg::vec_t ang;
    assign dx  = y[i] >>> i;
    assign dy  = x[i] >>> i;
    assign ang = e2q_pkg::vec_t'({2'b00, e2q_pkg::ATAN_TURN[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        upper[i+1] <= upper[i];
        if (!z[i][e2q_pkg::VEC_W-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ang;
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ang;
        end
      end
    end
  end

  // undo the quadrant fold
  e2q_pkg::vec_t neg_y;
  assign neg_y   = -y[STEPS];
  assign sin_val = upper[STEPS] ? e2q_pkg::trig_t'(x[STEPS]) : e2q_pkg::trig_t'(y[STEPS]);
  assign cos_val = upper[STEPS] ? e2q_pkg::trig_t'(neg_y) : e2q_pkg::trig_t'(x[STEPS]);

  // z of the last stage is only a residue
  logic unused_z;
  assign unused_z = ^z[STEPS];

endmodule

// File: rtl/core/e2q_merge.sv
// Merging stage: pair products, triple products, rounding and saturation
// to Q1.FRAC_BITS. Depends on e2q_pkg.
module e2q_merge #(
  parameter int FRAC_BITS = 15
) (
  input  logic                  clk,
  input  logic                  en,
  input  e2q_pkg::trig_t        sr,
  input  e2q_pkg::trig_t        cr,
  input  e2q_pkg::trig_t        sp,
  input  e2q_pkg::trig_t        cp,
  input  e2q_pkg::trig_t        sy,
  input  e2q_pkg::trig_t        cy,
  output logic [FRAC_BITS:0]    qx,
  output logic [FRAC_BITS:0]    qy,
  output logic [FRAC_BITS:0]    qz,
  output logic [FRAC_BITS:0]    qw
);

  localparam int PW = 2 * e2q_pkg::TRIG_W;
  localparam int SW = PW + 2;
  localparam int SH = 60 - FRAC_BITS;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  prod_t p_crcp, p_srsp, p_srcp, p_crsp;
  e2q_pkg::trig_t sy1, cy1, sy2, cy2;
  e2q_pkg::trig_t crcp, srsp, srcp, crsp;
  prod_t t_x0, t_x1, t_y0, t_y1, t_z0, t_z1, t_w0, t_w1;

  // multiply the roll and pitch pairs
  always_ff @(posedge clk) begin
    if (en) begin
      p_crcp <= cr * cp;
      p_srsp <= sr * sp;
      p_srcp <= sr * cp;
      p_crsp <= cr * sp;
      sy1    <= sy;
      cy1    <= cy;
    end
  end

  function automatic e2q_pkg::trig_t round30(input prod_t v);
    prod_t r;
    r = (v + (prod_t'(1) <<< 29)) >>> 30;
    return e2q_pkg::trig_t'(r);
  endfunction

  // round pairs back to Q30
  always_ff @(posedge clk) begin
    if (en) begin
      crcp <= round30(p_crcp);
      srsp <= round30(p_srsp);
      srcp <= round30(p_srcp);
      crsp <= round30(p_crsp);
      sy2  <= sy1;
      cy2  <= cy1;
    end
  end

  // multiply each pair by the yaw term
  always_ff @(posedge clk) begin
    if (en) begin
      t_x0 <= srcp * cy2;
      t_x1 <= crsp * sy2;
      t_y0 <= crsp * cy2;
      t_y1 <= srcp * sy2;
      t_z0 <= crcp * sy2;
      t_z1 <= srsp * cy2;
      t_w0 <= crcp * cy2;
      t_w1 <= srsp * sy2;
    end
  end

  function automatic logic [FRAC_BITS:0] finish(input sum_t v);
    sum_t r;
    sum_t hi;
    sum_t lo;
    r  = (v + (sum_t'(1) <<< (SH - 1))) >>> SH;
    hi = (sum_t'(1) <<< FRAC_BITS) - sum_t'(1);
    lo = -(sum_t'(1) <<< FRAC_BITS);
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[FRAC_BITS:0];
  endfunction

  // combine, round and saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      qx <= finish(sum_t'(t_x0) - sum_t'(t_x1));
      qy <= finish(sum_t'(t_y0) + sum_t'(t_y1));
      qz <= finish(sum_t'(t_z0) - sum_t'(t_z1));
      qw <= finish(sum_t'(t_w0) + sum_t'(t_w1));
    end
  end

endmodule

// File: rtl/core/euler_to_quaternion.sv
// Top level of the Euler-to-quaternion converter: three CORDIC lanes and
// the merging stage. Depends on e2q_pkg, e2q_cordic_lane and e2q_merge.
//
// Converts roll, pitch and yaw binary angles (2^ANGLE_BITS per turn) into a
// saturated unit quaternion in Q1.FRAC_BITS. One request is accepted every
// clock while out of reset and no result is stalled at the output; each
// result passes the load and micro-rotation registers of the half-angle CORDIC
// lanes, then the product and rounding stage, the last of which is the output
// register. The whole pipeline holds while a result waits on m_tready.
module euler_to_quaternion #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [47:0]                         s_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((4*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata  // qx, qy, qz, qw
);

  localparam int QW  = FRAC_BITS + 1;
  localparam int OW  = ((4 * QW + 7) / 8) * 8;
  localparam int LAT = 1 + e2q_pkg::CORDIC_STEPS + e2q_pkg::MERGE_STAGES;

  logic en;
  logic [LAT-1:0] vld;
  e2q_pkg::trig_t sr, cr, sp, cp, sy, cy;
  logic [QW-1:0] qx, qy, qz, qw;

  // advance unless a result is stalled at the output; refuse requests in reset
  assign en       = !(vld[LAT-1] && !m_tready);
  assign s_tready = en && !rst;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .en(en), .angle(s_tdata[15:0]),  .sin_val(sr), .cos_val(cr)
  );
  e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(s_tdata[31:16]), .sin_val(sp), .cos_val(cp)
  );
  e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(s_tdata[47:32]), .sin_val(sy), .cos_val(cy)
  );

  e2q_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .en(en),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .qx(qx), .qy(qy), .qz(qz), .qw(qw)
  );

  assign m_tdata = OW'({qw, qz, qy, qx});

endmodule
